FILE: rtl/rxs_pkg.sv
`default_nettype none
package rxs_pkg;
  localparam int SIZE_W = 11;
  localparam int IDX_W  = 10;
  localparam int MASK_W = 32;
  localparam int SUM_W  = 42;

  localparam logic ACT_XOR = 1'b0;
  localparam logic ACT_SUM = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RUN   = 3'b100
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/rxs_mem.sv
`default_nettype none
module rxs_mem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/range_xor_range_sum_tree.sv
`default_nettype none
// channel | direction | ports
// in      | in        | in_valid, in_ready, in_action, in_range_low, in_range_high, in_xor_mask
// out     | out       | out_valid, out_ready, out_range_sum
// cfg     | in        | cfg_we, cfg_wdata (size_in_use)
// An item sweeps its word range through one memory read port, one word a cycle.
// Empty or invalid ranges (low > high, high >= size, XOR with a zero mask) read no words.
// Read data is XORed and written back the next cycle, or added into the sum.
// Reset and every cfg write start a clearing pass that zeroes all ENTRIES words, no items taken.
// A finished query waits in the output register and a new beat is taken meanwhile;
// a second sum query holds at its end until that register is free.
module range_xor_range_sum_tree #(
  parameter int ENTRIES   = 1024,
  parameter int WORD_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_action,
  input  wire logic [rxs_pkg::IDX_W-1:0] in_range_low,
  input  wire logic [rxs_pkg::IDX_W-1:0] in_range_high,
  input  wire logic [rxs_pkg::MASK_W-1:0] in_xor_mask,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [rxs_pkg::SUM_W-1:0]      out_range_sum,
  input  wire logic                      cfg_we,
  input  wire logic [rxs_pkg::SIZE_W-1:0] cfg_wdata
);
  localparam int AW       = $clog2(ENTRIES);
  localparam int SIZE_MAX = (ENTRIES > 2047) ? 2047 : ENTRIES;
  localparam int CW       = rxs_pkg::IDX_W + 1;

  rxs_pkg::state_t state_r, state_nxt;
  logic [rxs_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt, hi_r, hi_nxt;
  logic            go_r, go_nxt, pend_r, pend_nxt, act_r, act_nxt;
  logic [AW-1:0]   addr_d_r, addr_d_nxt;
  logic [WORD_BITS-1:0] mask_r, mask_nxt;
  logic [rxs_pkg::SUM_W-1:0] acc_r, acc_nxt, osum_r, osum_nxt;
  logic            ov_r, ov_nxt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
  logic            issue, item_ok;

  rxs_mem #(.DEPTH(ENTRIES), .DW(WORD_BITS)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign in_ready      = (state_r == rxs_pkg::ST_IDLE);
  assign out_valid     = ov_r;
  assign out_range_sum = osum_r;

  assign issue   = (state_r == rxs_pkg::ST_RUN) && go_r && (cnt_r <= hi_r);
  assign item_ok = (in_range_low <= in_range_high) &&
                   ({1'b0, in_range_high} < size_r) &&
                   ((in_action == rxs_pkg::ACT_SUM) || (in_xor_mask[WORD_BITS-1:0] != '0));

  always_comb begin
    state_nxt  = state_r;
    size_nxt   = size_r;
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    hi_nxt     = hi_r;
    go_nxt     = go_r;
    act_nxt    = act_r;
    mask_nxt   = mask_r;
    acc_nxt    = acc_r;
    osum_nxt   = osum_r;
    ov_nxt     = ov_r;
    pend_nxt   = issue;
    addr_d_nxt = AW'(cnt_r);
    mem_re     = issue;
    mem_raddr  = AW'(cnt_r);
    mem_we     = 1'b0;
    mem_waddr  = addr_d_r;
    mem_wdata  = mem_rdata ^ mask_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      rxs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(ENTRIES - 1)) begin
          state_nxt = rxs_pkg::ST_IDLE;
        end
      end
      rxs_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rxs_pkg::ST_RUN;
          cnt_nxt   = CW'(in_range_low);
          hi_nxt    = CW'(in_range_high);
          go_nxt    = item_ok;
          act_nxt   = in_action;
          mask_nxt  = in_xor_mask[WORD_BITS-1:0];
          acc_nxt   = '0;
        end
      end
      rxs_pkg::ST_RUN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (pend_r) begin
          if (act_r == rxs_pkg::ACT_XOR) begin
            mem_we = 1'b1;
          end else begin
            acc_nxt = acc_r + rxs_pkg::SUM_W'(mem_rdata);
          end
        end
        if (!issue && !pend_r) begin
          if (act_r == rxs_pkg::ACT_XOR) begin
            state_nxt = rxs_pkg::ST_IDLE;
          end else if (!ov_r || out_ready) begin
            ov_nxt    = 1'b1;
            osum_nxt  = acc_r;
            state_nxt = rxs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rxs_pkg::ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    if (cfg_we) begin
      state_nxt = rxs_pkg::ST_CLEAR;
      clr_nxt   = '0;
      if (cfg_wdata == '0) begin
        size_nxt = rxs_pkg::SIZE_W'(1);
      end else if (32'(cfg_wdata) > SIZE_MAX) begin
        size_nxt = rxs_pkg::SIZE_W'(SIZE_MAX);
      end else begin
        size_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rxs_pkg::ST_CLEAR;
      size_r  <= rxs_pkg::SIZE_W'(SIZE_MAX);
      clr_r   <= '0;
      pend_r  <= 1'b0;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    hi_r     <= hi_nxt;
    act_r    <= act_nxt;
    mask_r   <= mask_nxt;
    acc_r    <= acc_nxt;
    osum_r   <= osum_nxt;
    addr_d_r <= addr_d_nxt;
  end
endmodule
`default_nettype wire
